[hw/rtl/jsfe_pkg.sv]
// Shared types and constants of the JSON string field extractor.
`default_nettype none
package jsfe_pkg;

  localparam int MAX_KEY_BYTES = 24;
  localparam int KLEN_W        = 5;
  localparam int CAP_W         = 16;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int KEY_WORDS     = 3;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = 2;
  localparam int FIFO_CNT_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LO   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_MID  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HI   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 3'd4;

  localparam logic [KLEN_W-1:0] KEY_LEN_RESET  = 5'd1;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 16'd256;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOKEY = 2'd1,
    ST_EMPTY = 2'd2,
    ST_LONG  = 2'd3
  } jsfe_status_t;

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_VALUE,
    PH_DONE
  } jsfe_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } jsfe_tap_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } jsfe_cell_ctrl_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             is_final;
    jsfe_status_t     status;
    logic [CAP_W-1:0] value_length;
  } jsfe_result_t;

  typedef struct packed {
    logic [1:0]   n;
    jsfe_result_t first;
    jsfe_result_t second;
  } jsfe_push_t;

endpackage
`default_nettype wire

[hw/rtl/jsfe_ifs.sv]
// Valid/ready channel interfaces for text input and result output.
`default_nettype none
interface jsfe_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsfe_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_final;
  logic [1:0]  status;
  logic [15:0] value_length;

  modport source (output valid, output out_byte, output is_final, output status,
                  output value_length, input ready);
  modport sink (input valid, input out_byte, input is_final, input status,
                input value_length, output ready);
endinterface
`default_nettype wire

[hw/rtl/jsfe_cell.sv]
// One window cell: holds a text byte, passes it on and compares the next byte with a key byte.
`default_nettype none
module jsfe_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  jsfe_pkg::jsfe_cell_ctrl_t ctrl,
  input  jsfe_pkg::jsfe_tap_t       tap_in,
  input  logic [7:0]                key_byte,
  input  logic                      in_use,
  output jsfe_pkg::jsfe_tap_t       tap_out,
  output logic                      match
);
  import jsfe_pkg::*;

  logic       valid;
  logic [7:0] data;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= tap_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= tap_in.data;
    end
  end

  assign tap_out = '{valid: valid, data: data};

  // Compare the byte this cell takes on shift.
  assign match = !in_use || (tap_in.valid && (tap_in.data == key_byte));

endmodule
`default_nettype wire

[hw/rtl/jsfe_out_fifo.sv]
// Four-entry result queue taking up to two results per cycle.
`default_nettype none
module jsfe_out_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  jsfe_pkg::jsfe_push_t push,
  output logic                 room,
  jsfe_result_if.source        result_ch
);
  import jsfe_pkg::*;

  jsfe_result_t            mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic                    pop;
  jsfe_result_t            head;

  assign pop  = result_ch.valid && result_ch.ready;
  assign room = count <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.n);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end
  end

  assign head                   = mem[rd_ptr];
  assign result_ch.valid        = count != '0;
  assign result_ch.out_byte     = head.out_byte;
  assign result_ch.is_final     = head.is_final;
  assign result_ch.status       = head.status;
  assign result_ch.value_length = head.value_length;

endmodule
`default_nettype wire

[hw/rtl/json_string_field_extractor_unit.sv]
// Top level of the JSON string field extractor.
`default_nettype none
// Scans a text one byte per cycle for a configured key (0 to 24 bytes, quotes and
// colon included) and then copies the string value that follows, undoing the
// escapes \/ \n \t \r \" and \\ and dropping any other escape pair. Each kept
// byte leaves as one result transaction; a final status transaction (ok, key not
// found, empty value, value too long) closes the run for each text, and an
// end_of_text transaction readies the block for the next text. Throughput is one
// text transaction per cycle while ready is high: the key search is a row of 24
// window cells that shift in the new byte and compare it against the key in the
// same cycle, and the value decoder updates its state in that cycle too. Results
// pass through a four-entry result queue; ready is low while the queue has fewer
// than two free entries, since an end_of_text after a trailing backslash yields
// two results. Configuration writes go through cfg_we/cfg_index/cfg_data; the
// user makes them only while the block is idle; the block does not enforce it.
module json_string_field_extractor_unit (
  input  logic                             clk,
  input  logic                             rst,
  jsfe_text_if.sink                        text_ch,
  jsfe_result_if.source                    result_ch,
  input  logic                             cfg_we,
  input  logic [jsfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jsfe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jsfe_pkg::*;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] key_word [KEY_WORDS];
  logic [KLEN_W-1:0]     key_length;
  logic [CAP_W-1:0]      capacity;

  // Run state.
  jsfe_phase_t      phase;
  jsfe_phase_t      phase_next;
  logic             esc;
  logic             esc_next;
  logic [CAP_W-1:0] count;
  logic [CAP_W-1:0] count_next;

  logic             room;
  logic             accept;
  logic             is_byte;
  logic [7:0]       c;
  logic [KLEN_W-1:0] klen;
  logic [CAP_W-1:0] cap_eff;
  logic [CAP_W-1:0] count_inc;
  logic             too_long;
  logic             hit;

  logic [7:0]       key_arr [MAX_KEY_BYTES];
  jsfe_tap_t        tap [MAX_KEY_BYTES];
  logic [MAX_KEY_BYTES-1:0] cell_match;
  jsfe_cell_ctrl_t  cell_ctrl;

  jsfe_push_t       push;

  // Escape decode of the current byte.
  logic             esc_known;
  logic [7:0]       esc_byte;

  // Take configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_word[i] <= '0;
      end
      key_length <= KEY_LEN_RESET;
      capacity   <= CAPACITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LO:   key_word[0] <= cfg_data;
        CFG_KEY_MID:  key_word[1] <= cfg_data;
        CFG_KEY_HI:   key_word[2] <= cfg_data;
        CFG_KEY_LEN:  key_length  <= cfg_data[KLEN_W-1:0];
        CFG_CAPACITY: capacity    <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the key length; treat capacity zero as one.
  assign klen    = (key_length > KLEN_W'(MAX_KEY_BYTES)) ? KLEN_W'(MAX_KEY_BYTES)
                                                          : key_length;
  assign cap_eff = (capacity == '0) ? CAP_W'(1) : capacity;

  assign count_inc = count + CAP_W'(1);
  // A byte fits only while count + 1 stays below the capacity.
  assign too_long  = ({1'b0, count} + (CAP_W+1)'(1)) >= {1'b0, cap_eff};

  assign text_ch.ready = room;
  assign accept        = text_ch.valid && text_ch.ready;
  assign is_byte       = accept && !text_ch.end_of_text;
  assign c             = text_ch.text_byte;

  // Window shifts only while searching with a non-empty key; end of text clears it.
  assign cell_ctrl.shift = is_byte && (phase == PH_SEARCH) && (klen != '0);
  assign cell_ctrl.clear = accept && text_ch.end_of_text;

  genvar j;
  generate
    for (j = 0; j < MAX_KEY_BYTES; j++) begin : g_cell
      jsfe_tap_t         tap_in;
      logic              in_use;
      logic [KLEN_W-1:0] key_idx;
      logic [7:0]        key_sel;

      assign key_arr[j] = key_word[j / 8][(j % 8) * 8 +: 8];

      if (j == 0) begin : g_head
        assign tap_in = '{valid: 1'b1, data: c};
      end else begin : g_body
        assign tap_in = tap[j-1];
      end

      // Cell j holds the byte that must equal key byte klen-1-j.
      assign in_use  = klen > KLEN_W'(j);
      assign key_idx = klen - KLEN_W'(j) - KLEN_W'(1);
      assign key_sel = in_use ? key_arr[key_idx] : 8'h00;

      jsfe_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .tap_in   (tap_in),
        .key_byte (key_sel),
        .in_use   (in_use),
        .tap_out  (tap[j]),
        .match    (cell_match[j])
      );
    end
  endgenerate

  assign hit = &cell_match;

  always_comb begin
    esc_known = 1'b1;
    esc_byte  = c;
    case (c)
      CH_SLASH:     esc_byte = CH_SLASH;
      CH_N:         esc_byte = CH_LF;
      CH_T:         esc_byte = CH_TAB;
      CH_R:         esc_byte = CH_CR;
      CH_QUOTE:     esc_byte = CH_QUOTE;
      CH_BACKSLASH: esc_byte = CH_BACKSLASH;
      default:      esc_known = 1'b0;
    endcase
  end

  // Phase, escape flag and byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      esc   <= 1'b0;
      count <= '0;
    end else begin
      phase <= phase_next;
      esc   <= esc_next;
      count <= count_next;
    end
  end

  always_comb begin
    logic       val_go;
    logic       emit;
    logic [7:0] emit_val;

    phase_next = phase;
    esc_next   = esc;
    count_next = count;
    push       = '0;
    val_go     = 1'b0;
    emit       = 1'b0;
    emit_val   = c;

    if (accept && text_ch.end_of_text) begin
      case (phase)
        PH_SEARCH: begin
          push.n                  = 2'd1;
          push.first.is_final     = 1'b1;
          push.first.status       = (klen == '0) ? ST_EMPTY : ST_NOKEY;
          push.first.value_length = count;
        end
        PH_VALUE: begin
          if (esc) begin
            // Keep the trailing backslash if it fits, then close the run.
            if (too_long) begin
              push.n                  = 2'd1;
              push.first.is_final     = 1'b1;
              push.first.status       = ST_LONG;
              push.first.value_length = count;
            end else begin
              push.n                   = 2'd2;
              push.first.out_byte      = CH_BACKSLASH;
              push.first.value_length  = count_inc;
              push.second.is_final     = 1'b1;
              push.second.status       = ST_OK;
              push.second.value_length = count_inc;
            end
          end else begin
            push.n                  = 2'd1;
            push.first.is_final     = 1'b1;
            push.first.status       = (count != '0) ? ST_OK : ST_EMPTY;
            push.first.value_length = count;
          end
        end
        default: ;
      endcase
      phase_next = PH_SEARCH;
      esc_next   = 1'b0;
      count_next = '0;
    end else if (is_byte) begin
      case (phase)
        PH_SEARCH: begin
          if (klen == '0) begin
            // Empty key: the value starts at the first byte.
            phase_next = PH_VALUE;
            val_go     = 1'b1;
          end else if (hit) begin
            phase_next = PH_VALUE;
          end
        end
        PH_VALUE: val_go = 1'b1;
        default: ;
      endcase

      if (val_go) begin
        if (esc) begin
          esc_next = 1'b0;
          emit     = esc_known;
          emit_val = esc_byte;
        end else if (c == CH_QUOTE) begin
          push.n                  = 2'd1;
          push.first.is_final     = 1'b1;
          push.first.status       = (count != '0) ? ST_OK : ST_EMPTY;
          push.first.value_length = count;
          phase_next              = PH_DONE;
        end else if (c == CH_BACKSLASH) begin
          esc_next = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end

      if (emit) begin
        push.n = 2'd1;
        if (too_long) begin
          push.first.is_final     = 1'b1;
          push.first.status       = ST_LONG;
          push.first.value_length = count;
          phase_next              = PH_DONE;
        end else begin
          push.first.out_byte     = emit_val;
          push.first.value_length = count_inc;
          count_next              = count_inc;
        end
      end
    end
  end

  jsfe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .result_ch (result_ch)
  );

endmodule
`default_nettype wire

[hw/rtl/jsfe_checker.sv]
// Port-level checks of the extractor's result channel, bound to the top level.
`default_nettype none
module jsfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  res_byte,
  input logic        res_final,
  input logic [1:0]  res_status,
  input logic [15:0] res_length
);
  import jsfe_pkg::*;

  // Queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_byte) && $stable(res_final)
                                  && $stable(res_status) && $stable(res_length)))
    else $error("stalled result changed");

  // Value bytes carry status ok and a nonzero running length.
  a_value_item: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_final) |-> (res_status == ST_OK && res_length != 16'd0))
    else $error("bad value byte result");

  // Empty or missing values report zero length and no byte.
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_final && (res_status == ST_EMPTY || res_status == ST_NOKEY))
      |-> (res_length == 16'd0 && res_byte == 8'd0))
    else $error("empty status with nonzero length");

endmodule

bind json_string_field_extractor_unit jsfe_checker u_jsfe_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result_ch.valid),
  .res_ready  (result_ch.ready),
  .res_byte   (result_ch.out_byte),
  .res_final  (result_ch.is_final),
  .res_status (result_ch.status),
  .res_length (result_ch.value_length)
);
`default_nettype wire

[verif/tb_json_string_field_extractor_unit.sv]
// Self-checking testbench for the JSON string field extractor: random texts against a predictor.
module tb_json_string_field_extractor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jsfe_pkg::*;

  // Random stall percentage, the watchdog bound on cycles with no transaction, and the item budget.
  localparam int STALL_PCT    = 16;
  localparam int WATCHDOG_MAX = 2000;
  localparam int ITEM_TARGET  = 1450;

  typedef struct packed {
    logic [7:0] data;
    logic       ends;
  } text_item_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  jsfe_text_if   text_ch ();
  jsfe_result_if result_ch ();

  json_string_field_extractor_unit uut (
    .clk       (clk),
    .rst       (rst),
    .text_ch   (text_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Text bytes waiting for the driver, and the value bytes / status items still owed.
  text_item_t   pending_text [$];
  jsfe_result_t extracted_due [$];

  int  items_queued;
  int  items_accepted;
  int  results_checked;
  int  failures;
  int  settings_used;
  int  idle_cycles;
  logic calm;

  // Mirror of the configuration registers.
  logic [63:0]       key_word [KEY_WORDS];
  logic [KLEN_W-1:0] key_len_cfg;
  logic [CAP_W-1:0]  cap_cfg;

  // Mirror of the scan state: newest byte sits in recent[0].
  logic [7:0]   recent [MAX_KEY_BYTES];
  int           recent_fill;
  jsfe_phase_t  scan_state;
  logic         escape_armed;
  logic [15:0]  kept_bytes;

  // ---------------------------------------------------------------------------
  // Extraction predictor
  // ---------------------------------------------------------------------------

  // Lengths above the window size saturate to the window size.
  function automatic int key_span();
    int k = key_len_cfg;
    return (k > MAX_KEY_BYTES) ? MAX_KEY_BYTES : k;
  endfunction

  function automatic logic [7:0] key_at(int i);
    return key_word[i / 8][(i % 8) * 8 +: 8];
  endfunction

  task automatic restart_scan();
    for (int j = 0; j < MAX_KEY_BYTES; j++) recent[j] = 8'h00;
    recent_fill  = 0;
    scan_state   = PH_SEARCH;
    escape_armed = 1'b0;
    kept_bytes   = '0;
  endtask

  task automatic owe_result(logic [7:0] b, logic fin, jsfe_status_t st);
    jsfe_result_t r;
    r.out_byte     = b;
    r.is_final     = fin;
    r.status       = st;
    r.value_length = kept_bytes;
    extracted_due.push_back(r);
  endtask

  // Keep one value byte, or close the run as too long once capacity minus one is reached.
  task automatic keep_value_byte(logic [7:0] b);
    int lim;
    lim = (cap_cfg == '0) ? 1 : int'(cap_cfg);
    if (int'(kept_bytes) + 1 >= lim) begin
      owe_result(8'h00, 1'b1, ST_LONG);
      scan_state = PH_DONE;
    end else begin
      kept_bytes++;
      owe_result(b, 1'b0, ST_OK);
    end
  endtask

  task automatic decode_value_byte(logic [7:0] c);
    if (escape_armed) begin
      escape_armed = 1'b0;
      case (c)
        CH_SLASH:     keep_value_byte(CH_SLASH);
        CH_N:         keep_value_byte(CH_LF);
        CH_T:         keep_value_byte(CH_TAB);
        CH_R:         keep_value_byte(CH_CR);
        CH_QUOTE:     keep_value_byte(CH_QUOTE);
        CH_BACKSLASH: keep_value_byte(CH_BACKSLASH);
        default: ; // drop an unknown escape pair
      endcase
    end else if (c == CH_QUOTE) begin
      owe_result(8'h00, 1'b1, (kept_bytes != '0) ? ST_OK : ST_EMPTY);
      scan_state = PH_DONE;
    end else if (c == CH_BACKSLASH) begin
      escape_armed = 1'b1;
    end else begin
      keep_value_byte(c);
    end
  endtask

  // Advance the predictor by one accepted text transaction.
  task automatic extract_step(logic [7:0] c, logic ends);
    int  klen;
    logic hit;
    klen = key_span();
    if (ends) begin
      if (scan_state == PH_SEARCH) begin
        owe_result(8'h00, 1'b1, (klen == 0) ? ST_EMPTY : ST_NOKEY);
      end else if (scan_state == PH_VALUE) begin
        // A dangling backslash survives as a literal byte.
        if (escape_armed) begin
          escape_armed = 1'b0;
          keep_value_byte(CH_BACKSLASH);
        end
        if (scan_state == PH_VALUE)
          owe_result(8'h00, 1'b1, (kept_bytes != '0) ? ST_OK : ST_EMPTY);
      end
      restart_scan();
    end else if (scan_state == PH_SEARCH) begin
      if (klen == 0) begin
        // An empty key matches before the first byte, so this byte is already value.
        scan_state = PH_VALUE;
        decode_value_byte(c);
      end else begin
        for (int j = MAX_KEY_BYTES - 1; j > 0; j--) recent[j] = recent[j - 1];
        recent[0] = c;
        if (recent_fill < MAX_KEY_BYTES) recent_fill++;
        hit = (recent_fill >= klen);
        for (int j = 0; j < klen; j++)
          if (recent[j] != key_at(klen - 1 - j)) hit = 1'b0;
        if (hit) scan_state = PH_VALUE;
      end
    end else if (scan_state == PH_VALUE) begin
      decode_value_byte(c);
    end
    // after the run is closed, bytes are ignored until end of text
  endtask

  // ---------------------------------------------------------------------------
  // Driver, acceptance tracking, result checker, watchdog
  // ---------------------------------------------------------------------------

  // Present the next pending byte, or hold back at random unless in the calm stretch.
  always @(posedge clk) begin : drive_text
    text_item_t nxt;
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (pending_text.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
        nxt = pending_text.pop_front();
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= nxt.data;
        text_ch.end_of_text <= nxt.ends;
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random, except in the calm stretch.
  always @(posedge clk) begin : drive_ready
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end
  end

  // Predict on every accepted text transaction; count and prediction move together.
  always @(posedge clk) begin : track_text
    if (!rst && text_ch.valid && text_ch.ready) begin
      extract_step(text_ch.text_byte, text_ch.end_of_text);
      items_accepted++;
    end
  end

  // Compare each result transaction with the oldest owed result, field by field.
  always @(posedge clk) begin : check_results
    jsfe_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_checked++;
      if (extracted_due.size() == 0) begin
        $error("unexpected result: out_byte %02h is_final %0d status %0d value_length %0d",
               result_ch.out_byte, result_ch.is_final, result_ch.status,
               result_ch.value_length);
        failures++;
      end else begin
        want = extracted_due.pop_front();
        if (result_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, result_ch.out_byte);
          failures++;
        end
        if (result_ch.is_final !== want.is_final) begin
          $error("is_final: expected %0d, got %0d", want.is_final, result_ch.is_final);
          failures++;
        end
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_ch.status);
          failures++;
        end
        if (result_ch.value_length !== want.value_length) begin
          $error("value_length: expected %0d, got %0d",
                 want.value_length, result_ch.value_length);
          failures++;
        end
      end
    end
  end

  // Count cycles in which work is outstanding but no transaction moves.
  always @(posedge clk) begin : watchdog
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (items_accepted == items_queued && extracted_due.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $error("no transaction for %0d cycles: %0d results owed, %0d bytes unsent",
             WATCHDOG_MAX, extracted_due.size(), items_queued - items_accepted);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_byte(logic [7:0] b);
    pending_text.push_back('{data: b, ends: 1'b0});
    items_queued++;
  endtask

  // The byte carried with end of text is ignored; randomize it anyway.
  task automatic queue_end();
    pending_text.push_back('{data: 8'($urandom_range(0, 255)), ends: 1'b1});
    items_queued++;
  endtask

  // Wait until every byte is accepted and every owed result has arrived, then let the
  // pipeline settle so a trailing no-result byte is finished too.
  task automatic wait_drained();
    while (items_accepted != items_queued || extracted_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_KEY_LO:   key_word[0] = data;
      CFG_KEY_MID:  key_word[1] = data;
      CFG_KEY_HI:   key_word[2] = data;
      CFG_KEY_LEN:  key_len_cfg = data[KLEN_W-1:0];
      CFG_CAPACITY: cap_cfg     = data[CAP_W-1:0];
      default: ;
    endcase
  endtask

  // Program all five registers; only called with nothing in flight.
  task automatic program_settings(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                                  logic [KLEN_W-1:0] klen, logic [CAP_W-1:0] cap);
    wait_drained();
    write_reg(CFG_KEY_LO, k0);
    write_reg(CFG_KEY_MID, k1);
    write_reg(CFG_KEY_HI, k2);
    write_reg(CFG_KEY_LEN, CFG_DATA_W'(klen));
    write_reg(CFG_CAPACITY, CFG_DATA_W'(cap));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] value_char();
    int r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 80) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Value body: mostly plain characters, some escape pairs, a few unknown escapes.
  task automatic queue_value(int len);
    logic [7:0] esc_set [6];
    esc_set = '{CH_SLASH, CH_N, CH_T, CH_R, CH_QUOTE, CH_BACKSLASH};
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        queue_byte(CH_BACKSLASH);
        if ($urandom_range(0, 3) == 0) queue_byte(value_char());
        else queue_byte(esc_set[$urandom_range(0, 5)]);
      end else begin
        queue_byte(value_char());
      end
    end
  endtask

  // Noise that often reuses key bytes, so partial and shifted matches show up.
  task automatic queue_noise(int len);
    int klen;
    klen = key_span();
    for (int i = 0; i < len; i++) begin
      if (klen != 0 && $urandom_range(0, 99) < 30) queue_byte(key_at($urandom_range(0, klen - 1)));
      else queue_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_key();
    for (int i = 0; i < key_span(); i++) queue_byte(key_at(i));
  endtask

  // One text: mostly key plus value, closed by a quote, cut off, or ended on a backslash.
  task automatic queue_random_text();
    int mode;
    int vmax;
    int vlen;
    mode = $urandom_range(0, 99);
    vmax = (int'(cap_cfg) + 2 > 40) ? 40 : int'(cap_cfg) + 2;
    vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, vmax) : $urandom_range(0, 10);
    queue_noise($urandom_range(0, 4));
    if (mode < 88) begin
      queue_key();
      queue_value(vlen);
      if (mode < 62) begin
        queue_byte(CH_QUOTE);
        queue_noise($urandom_range(0, 3));
      end else if (mode >= 74) begin
        queue_byte(CH_BACKSLASH);
      end
    end else begin
      queue_noise($urandom_range(1, 10));
    end
    queue_end();
  endtask

  // Random phase under one setting, drained once halfway so the sender waits on results.
  task automatic random_phase(logic [KLEN_W-1:0] klen, logic [CAP_W-1:0] cap,
                              logic quiet, int n_items);
    int start;
    program_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     klen, cap);
    calm  = quiet;
    start = items_queued;
    while (items_queued - start < n_items / 2) queue_random_text();
    wait_drained();
    while (items_queued - start < n_items) queue_random_text();
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = 8'h00;
    text_ch.end_of_text = 1'b0;
    result_ch.ready     = 1'b0;
    items_queued        = 0;
    items_accepted      = 0;
    results_checked     = 0;
    failures            = 0;
    settings_used       = 1;
    idle_cycles         = 0;
    calm                = 1'b0;
    key_word            = '{64'h0, 64'h0, 64'h0};
    key_len_cfg         = KEY_LEN_RESET;
    cap_cfg             = CAPACITY_RESET;
    restart_scan();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a one-byte key of 0x00. A text of 0xFF misses; a zero byte is
    // an ordinary byte that matches, and a quote closes the value.
    queue_byte(8'hFF);
    queue_end();
    queue_byte(8'h00);
    queue_byte(8'h78);
    queue_byte(CH_QUOTE);
    queue_end();

    // Key a:" with capacity 7: all six escapes fill the value to exactly six bytes,
    // an unknown escape is dropped, the next byte is too long and the quote is ignored.
    program_settings(64'h0000_0000_0022_3A61, 64'h0, 64'h0, 5'd3, 16'd7);
    queue_key();
    queue_byte(CH_BACKSLASH); queue_byte(CH_SLASH);
    queue_byte(CH_BACKSLASH); queue_byte(CH_N);
    queue_byte(CH_BACKSLASH); queue_byte(CH_T);
    queue_byte(CH_BACKSLASH); queue_byte(CH_R);
    queue_byte(CH_BACKSLASH); queue_byte(CH_QUOTE);
    queue_byte(CH_BACKSLASH); queue_byte(CH_BACKSLASH);
    queue_byte(CH_BACKSLASH); queue_byte(8'h71);
    queue_byte(8'h7A);
    queue_byte(CH_QUOTE);
    queue_end();
    // Quote right after the key: empty value.
    queue_key();
    queue_byte(CH_QUOTE);
    queue_end();

    // Full-width key and largest capacity, with no idling on either side.
    random_phase(5'd24, 16'hFFFF, 1'b1, 220);
    // Extremes of key length and capacity, including the saturated and zero cases.
    random_phase(5'd1,  16'd1, 1'b0, 90);
    random_phase(5'd0,  16'd3, 1'b0, 90);
    random_phase(5'd31, 16'd0, 1'b0, 90);
    random_phase(5'd24, 16'd2, 1'b0, 90);
    // Mixed settings until the item budget is used up.
    while (items_queued < ITEM_TARGET) begin
      random_phase(5'($urandom_range(1, 23)),
                   ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(2, 24)),
                   1'b0, 110);
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d text transactions and %0d result transactions", items_accepted,
             results_checked);
    $display("over %0d register settings, key lengths 0 to 31 and capacities 0 to 65535",
             settings_used);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/jsfe_pkg.sv
hw/rtl/jsfe_ifs.sv
hw/rtl/jsfe_cell.sv
hw/rtl/jsfe_out_fifo.sv
hw/rtl/json_string_field_extractor_unit.sv
hw/rtl/jsfe_checker.sv
verif/tb_json_string_field_extractor_unit.sv
